[src/abad_pkg.sv]
// shared types and constants for the block-average voltage meter
package abad_pkg;

	localparam int FRAC_BITS = 16;
	localparam int GAIN_W    = 16;
	localparam int SPB_W     = 7;
	localparam int WHOLE_W   = 10;
	localparam int DIGIT_W   = 4;
	localparam int HUND_W    = 7;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 16;

	localparam logic [WHOLE_W-1:0] WHOLE_MAX = 10'd1023;
	localparam logic [HUND_W-1:0]  HUND_FULL = 7'd100;
	localparam logic [7:0]         TENTH_RECIP = 8'd205;
	localparam int                 TENTH_SHIFT = 11;
	localparam logic [3:0]         DEC_BASE = 4'd10;

	localparam logic [SPB_W-1:0]  SPB_RESET  = 7'd16;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd2000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SAMPLES_PER_BLOCK = 1'b0,
		REG_VOLTS_PER_COUNT   = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_FRAC,
		ST_DIGIT
	} state_t;

endpackage

[src/adc_block_average_decimal.sv]
// block-average voltage meter with shared restoring divider and decimal formatting
//
// Each request carries one ADC sample and yields one result with the held
// voltage as whole volts plus two rounded decimal digits, the sample itself and
// a valid flag. A sample that does not close a block passes only through the
// rounding and digit states. A sample that closes a block first goes through the
// gain multiply and then the restoring divider, which makes one quotient bit per
// cycle and divides the scaled sum by the sample count. No new request is taken
// until the previous one has reached the output register.
// The result sits in an output register, so the next sample is taken while a
// result waits; a following result that finds that register still full holds
// the block until the waiting one is taken.
module adc_block_average_decimal #(
	parameter int SAMPLE_BITS = 10,
	parameter int MAX_BLOCK   = 64
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_we,
	input  logic [abad_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  logic [abad_pkg::CFG_W-1:0]               cfg_data,
	input  logic                                     s_tvalid,
	output logic                                     s_tready,
	// sample
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]         s_tdata,
	output logic                                     m_tvalid,
	input  logic                                     m_tready,
	// volts_whole, tenths_digit, hundredths_digit, raw_latest
	output logic [((SAMPLE_BITS+18+7)/8)*8-1:0]      m_tdata,
	// measure_valid
	output logic                                     m_tuser
);

	localparam int IN_W     = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int OUT_W    = ((SAMPLE_BITS + 18 + 7) / 8) * 8;
	localparam int PAY_W    = SAMPLE_BITS + 18;
	localparam int CNT_W    = $clog2(MAX_BLOCK + 1);
	localparam int CMP_W    = (CNT_W > abad_pkg::SPB_W) ? CNT_W : abad_pkg::SPB_W;
	localparam int SUM_W    = SAMPLE_BITS + CNT_W;
	localparam int PW       = SUM_W + abad_pkg::GAIN_W;
	localparam int HELD_W   = SAMPLE_BITS + abad_pkg::FRAC_BITS;
	localparam int DCNT_W   = $clog2(PW);
	localparam int RND_W    = abad_pkg::FRAC_BITS + abad_pkg::HUND_W;

	abad_pkg::state_t state_q, state_d;

	logic [abad_pkg::SPB_W-1:0]  spb_q;
	logic [abad_pkg::GAIN_W-1:0] gain_q;
	logic [SUM_W-1:0]            sum_q;
	logic [CNT_W-1:0]            count_q;
	logic [HELD_W-1:0]           held_q;
	logic                        first_done_q;
	logic [SAMPLE_BITS-1:0]      raw_q;
	logic [PW-1:0]               prod_q;
	logic [CNT_W-1:0]            rem_q;
	logic [DCNT_W-1:0]           dcnt_q;
	logic [abad_pkg::HUND_W-1:0] hund_q;
	logic                        m_tvalid_q;
	logic [PAY_W-1:0]            out_q;
	logic                        out_user_q;

	logic                        accept;
	logic                        out_free;
	logic                        out_load;
	logic                        div_last;
	logic [CMP_W-1:0]            bsize;
	logic [CNT_W-1:0]            count_nxt;
	logic [SUM_W-1:0]            sum_nxt;
	logic                        block_end;
	logic [SAMPLE_BITS-1:0]      sample;
	logic [CNT_W:0]              trial;
	logic                        trial_ge;
	logic [CNT_W:0]              trial_sub;
	logic [RND_W-1:0]            rnd;
	logic                        carry;
	logic [abad_pkg::HUND_W-1:0] hund_adj;
	logic [SAMPLE_BITS:0]        whole_inc;
	logic [abad_pkg::WHOLE_W-1:0] whole_sat;
	logic [14:0]                 tenth_prod;
	logic [abad_pkg::DIGIT_W-1:0] tenths;
	logic [abad_pkg::HUND_W-1:0] hund_rem;

	assign sample    = s_tdata[SAMPLE_BITS-1:0];
	assign accept    = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign div_last  = (dcnt_q == '0);

	always_comb begin
		if (spb_q == '0) begin
			bsize = CMP_W'(1);
		end else if (CMP_W'(spb_q) > CMP_W'(MAX_BLOCK)) begin
			bsize = CMP_W'(MAX_BLOCK);
		end else begin
			bsize = CMP_W'(spb_q);
		end
	end

	assign count_nxt = count_q + CNT_W'(1);
	assign sum_nxt   = sum_q + SUM_W'(sample);
	assign block_end = CMP_W'(count_nxt) >= bsize;

	// one quotient bit per cycle
	assign trial     = {rem_q, prod_q[PW-1]};
	assign trial_ge  = trial >= {1'b0, count_q};
	assign trial_sub = trial - {1'b0, count_q};

	// round fraction to hundredths, half up
	assign rnd = RND_W'(held_q[abad_pkg::FRAC_BITS-1:0]) * RND_W'(abad_pkg::HUND_FULL)
		+ RND_W'(1 << (abad_pkg::FRAC_BITS - 1));

	assign carry     = (hund_q == abad_pkg::HUND_FULL);
	assign hund_adj  = carry ? '0 : hund_q;
	assign whole_inc = {1'b0, held_q[HELD_W-1:abad_pkg::FRAC_BITS]} + (SAMPLE_BITS+1)'(carry);
	assign whole_sat = (whole_inc > (SAMPLE_BITS+1)'(abad_pkg::WHOLE_MAX)) ?
		abad_pkg::WHOLE_MAX : abad_pkg::WHOLE_W'(whole_inc);
	assign tenth_prod = 15'(hund_adj) * 15'(abad_pkg::TENTH_RECIP);
	assign tenths     = tenth_prod[abad_pkg::TENTH_SHIFT +: abad_pkg::DIGIT_W];
	assign hund_rem   = hund_adj -
		abad_pkg::HUND_W'(tenths) * abad_pkg::HUND_W'(abad_pkg::DEC_BASE);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			abad_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = block_end ? abad_pkg::ST_MUL : abad_pkg::ST_FRAC;
				end
			end
			abad_pkg::ST_MUL:   state_d = abad_pkg::ST_DIV;
			abad_pkg::ST_DIV: begin
				if (div_last) begin
					state_d = abad_pkg::ST_FRAC;
				end
			end
			abad_pkg::ST_FRAC:  state_d = abad_pkg::ST_DIGIT;
			abad_pkg::ST_DIGIT: begin
				if (out_free) begin
					state_d = abad_pkg::ST_IDLE;
				end
			end
			default: state_d = abad_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			abad_pkg::ST_IDLE:  s_tready = 1'b1;
			abad_pkg::ST_DIGIT: out_load = out_free;
			default: begin
				s_tready = 1'b0;
				out_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= abad_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spb_q  <= abad_pkg::SPB_RESET;
			gain_q <= abad_pkg::GAIN_RESET;
		end else if (cfg_we) begin
			unique case (abad_pkg::reg_idx_t'(cfg_index))
				abad_pkg::REG_SAMPLES_PER_BLOCK: spb_q  <= cfg_data[abad_pkg::SPB_W-1:0];
				abad_pkg::REG_VOLTS_PER_COUNT:   gain_q <= cfg_data[abad_pkg::GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// accumulator and held voltage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q        <= '0;
			count_q      <= '0;
			held_q       <= '0;
			first_done_q <= 1'b0;
		end else if (accept) begin
			sum_q   <= sum_nxt;
			count_q <= count_nxt;
		end else if (state_q == abad_pkg::ST_DIV && div_last) begin
			held_q       <= prod_q[HELD_W-2:0] == '0 && !trial_ge ?
				'0 : {prod_q[HELD_W-2:0], trial_ge};
			sum_q        <= '0;
			count_q      <= '0;
			first_done_q <= 1'b1;
		end
	end

	// multiply, divide and rounding datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			raw_q <= sample;
		end
		unique case (state_q)
			abad_pkg::ST_MUL: begin
				prod_q <= PW'(sum_q) * PW'(gain_q);
				rem_q  <= '0;
				dcnt_q <= DCNT_W'(PW - 1);
			end
			abad_pkg::ST_DIV: begin
				prod_q <= {prod_q[PW-2:0], trial_ge};
				rem_q  <= trial_ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
				dcnt_q <= dcnt_q - DCNT_W'(1);
			end
			abad_pkg::ST_FRAC: begin
				hund_q <= rnd[RND_W-1:abad_pkg::FRAC_BITS];
			end
			default: ;
		endcase
		if (out_load) begin
			out_q      <= {raw_q, hund_rem[abad_pkg::DIGIT_W-1:0], tenths, whole_sat};
			out_user_q <= first_done_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OUT_W - PAY_W){1'b0}}, out_q};
	assign m_tuser  = out_user_q;

	logic unused_in;
	assign unused_in = ^{s_tdata[IN_W-1:0], 1'b0};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(count_q) <= CMP_W'(MAX_BLOCK))
		else $error("sample count above block limit");

	a_div_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == abad_pkg::ST_DIV && div_last) |=> (count_q == '0 && first_done_q))
		else $error("block end did not clear accumulator");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!m_tvalid || m_tready))
		else $error("result overwritten before taken");

	a_hund_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == abad_pkg::ST_DIGIT) |-> (hund_q <= abad_pkg::HUND_FULL))
		else $error("rounded hundredths out of range");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("request taken while previous one in flight");

endmodule

[tb/sv/testbench.sv]
// self-checking testbench for the block-average voltage meter
module testbench;

	localparam int MAX_BLOCK = 64;
	localparam int PHASES    = 11;
	localparam int PER_PHASE = 64;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	abad_pkg::reg_idx_t cfg_index;
	logic [15:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        m_tuser;

	logic send_idle_on;
	logic recv_idle_on;
	logic hold_req;

	typedef struct packed {
		logic [9:0] whole;
		logic [3:0] tenths;
		logic [3:0] hundredths;
		logic [9:0] raw;
		logic       valid;
	} reading_t;

	class meter_tracker;
		logic [6:0]  spb_reg;
		logic [15:0] gain_reg;
		logic [15:0] acc_sum;
		logic [6:0]  acc_count;
		logic [25:0] held_q16;
		logic        first_done;
		reading_t    pending_readings[$];
		int          fails;
		int          samples;
		int          blocks;

		function new();
			spb_reg    = abad_pkg::SPB_RESET;
			gain_reg   = abad_pkg::GAIN_RESET;
			acc_sum    = '0;
			acc_count  = '0;
			held_q16   = '0;
			first_done = 1'b0;
			fails      = 0;
			samples    = 0;
			blocks     = 0;
		endfunction

		function void set_reg(abad_pkg::reg_idx_t idx, logic [15:0] value);
			case (idx)
				abad_pkg::REG_SAMPLES_PER_BLOCK: spb_reg = value[6:0];
				abad_pkg::REG_VOLTS_PER_COUNT:   gain_reg = value;
				default: ;
			endcase
		endfunction

		function void note_sample(logic [9:0] smp);
			reading_t    r;
			logic [6:0]  eff;
			logic [63:0] prod;
			logic [63:0] scaled;
			logic [10:0] whole;
			logic [6:0]  hund;
			acc_sum   = acc_sum + 16'(smp);
			acc_count = acc_count + 7'd1;
			samples++;
			if (spb_reg == 0)
				eff = 7'd1;
			else if (spb_reg > MAX_BLOCK)
				eff = 7'(MAX_BLOCK);
			else
				eff = spb_reg;
			if (acc_count >= eff) begin
				prod       = 64'(acc_sum) * 64'(gain_reg);
				held_q16   = 26'(prod / 64'(acc_count));
				acc_sum    = '0;
				acc_count  = '0;
				first_done = 1'b1;
				blocks++;
			end
			whole  = 11'(held_q16 >> abad_pkg::FRAC_BITS);
			scaled = (64'(held_q16[abad_pkg::FRAC_BITS-1:0]) * 64'd100 + 64'd32768)
				>> abad_pkg::FRAC_BITS;
			hund   = 7'(scaled);
			if (hund >= abad_pkg::HUND_FULL) begin
				hund  = '0;
				whole = whole + 11'd1;
			end
			if (whole > 11'(abad_pkg::WHOLE_MAX))
				whole = 11'(abad_pkg::WHOLE_MAX);
			r.whole      = whole[9:0];
			r.tenths     = 4'(hund / 10);
			r.hundredths = 4'(hund % 10);
			r.raw        = smp;
			r.valid      = first_done;
			pending_readings.push_back(r);
		endfunction

		function void check_reading(logic [31:0] data, logic flag);
			reading_t exp_r;
			int       exp_f[5];
			int       act_f[5];
			string    names[5];
			if (pending_readings.size() == 0) begin
				$display("%0t: unexpected result data=%h user=%b", $time, data, flag);
				fails++;
				return;
			end
			exp_r = pending_readings.pop_front();
			names = '{"volts_whole", "tenths_digit", "hundredths_digit", "raw_latest",
				"measure_valid"};
			exp_f = '{exp_r.whole, exp_r.tenths, exp_r.hundredths, exp_r.raw, exp_r.valid};
			act_f = '{data[9:0], data[13:10], data[17:14], data[27:18], flag};
			foreach (names[i])
				if (exp_f[i] != act_f[i]) begin
					$display("%0t: %s expected %0d actual %0d", $time, names[i], exp_f[i],
						act_f[i]);
					fails++;
				end
		endfunction

		function int pending();
			return pending_readings.size();
		endfunction
	endclass

	meter_tracker tracker;
	int           settings;

	adc_block_average_decimal DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	initial begin
		#3000000;
		$display("FAIL adc_block_average_decimal");
		$finish;
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left  = 0;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				tracker.check_reading(m_tdata, m_tuser);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (recv_idle_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 19) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task send_sample(input logic [9:0] smp);
		if (send_idle_on && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'd0, smp};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		tracker.note_sample(smp);
	endtask

	task drain();
		s_tvalid <= 1'b0;
		while (tracker.pending() != 0 || !s_tready) @(posedge clk);
	endtask

	task write_config(input logic [15:0] spb_word, input logic [15:0] gain);
		cfg_we    <= 1'b1;
		cfg_index <= abad_pkg::REG_SAMPLES_PER_BLOCK;
		cfg_data  <= spb_word;
		@(posedge clk);
		tracker.set_reg(abad_pkg::REG_SAMPLES_PER_BLOCK, spb_word);
		cfg_index <= abad_pkg::REG_VOLTS_PER_COUNT;
		cfg_data  <= gain;
		@(posedge clk);
		tracker.set_reg(abad_pkg::REG_VOLTS_PER_COUNT, gain);
		cfg_we <= 1'b0;
		settings++;
	endtask

	function logic [9:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return 10'd0;
			1: return 10'd1023;
			default: return 10'($urandom_range(0, 1023));
		endcase
	endfunction

	initial begin
		logic [9:0]  vals[$];
		logic [6:0]  spb;
		logic [15:0] gain;
		tracker      = new();
		settings     = 0;
		send_idle_on = 1'b1;
		recv_idle_on = 1'b1;
		hold_req     = 1'b0;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= abad_pkg::REG_SAMPLES_PER_BLOCK;
		cfg_data  <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, block left open
		vals = '{10'd0, 10'd1023, 10'h2AA, 10'h155, 10'd512, 10'd1, 10'd1022, 10'd300};
		foreach (vals[i]) send_sample(vals[i]);
		drain();
		// single-sample blocks at full gain, rounding carries into whole volts
		write_config(16'd1, 16'hFFFF);
		vals = '{10'd0, 10'd1, 10'd1023, 10'd328, 10'd329, 10'h2AA, 10'h155};
		foreach (vals[i]) send_sample(vals[i]);
		drain();
		// zero block size and zero gain
		write_config(16'd0, 16'd0);
		vals = '{10'd1023, 10'd5, 10'd0};
		foreach (vals[i]) send_sample(vals[i]);
		drain();
		// block size lowered mid-block
		write_config(16'd3, 16'd40000);
		send_sample(10'd1000);
		send_sample(10'd17);
		drain();
		write_config(16'd1, 16'd40000);
		send_sample(10'd999);
		drain();
		write_config(16'd2, 16'd1);
		vals = '{10'd1023, 10'd1023, 10'd1, 10'd0};
		foreach (vals[i]) send_sample(vals[i]);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin spb = 7'd64;  gain = 16'hFFFF; end
				1: begin spb = 7'd127; gain = 16'd0;    end
				2: begin spb = 7'd1;   gain = 16'd2000; end
				3: begin spb = 7'd0;   gain = 16'hFFFF; end
				default: begin
					spb  = ($urandom_range(0, 5) == 0) ? 7'($urandom_range(0, 127))
						: 7'($urandom_range(1, 64));
					gain = 16'($urandom);
				end
			endcase
			if (p >= PHASES - 2) begin
				send_idle_on = 1'b0;
				recv_idle_on = 1'b0;
			end
			write_config({9'($urandom_range(0, 511)), spb}, gain);
			if (p == 1)
				hold_req = 1'b1;
			repeat (PER_PHASE) send_sample(pick_sample());
			drain();
		end

		repeat (40) @(posedge clk);
		tracker.fails += tracker.pending();
		$display("covered %0d samples, %0d block averages, %0d register settings",
			tracker.samples, tracker.blocks, settings);
		if (tracker.fails == 0)
			$display("PASS adc_block_average_decimal");
		else
			$display("FAIL adc_block_average_decimal");
		$finish;
	end

endmodule
